// File: rtl/rbfk_pkg.sv
// Shared types and constants for the RBF kernel evaluator.
// No dependencies; used by rbfk_ctrl, rbfk_dp and the top level.
`default_nettype none

package rbfk_pkg;

	localparam logic [47:0] ACC_MAX    = 48'hFFFF_FFFF_FFFF;
	localparam logic [21:0] X_MAX      = 22'h20_0000;   // 32.0 in Q.16
	localparam logic [16:0] LOG2E_Q16  = 17'd94548;
	localparam logic [63:0] LN2_Q30    = 64'd744261118;
	localparam logic [15:0] KV_ONE     = 16'd32768;     // 1.0 in Q1.15
	localparam logic [0:0]  REG_INV_GAMMA = 1'b0;       // register index
	localparam logic [31:0] INV_GAMMA_RST = 32'd65536;

	// controller -> datapath
	typedef struct packed {
		logic in_ready;
		logic mul_hi;
		logic mul_lo;
		logic scale;
		logic log2e;
		logic interp;
		logic load_out;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic fin_pending;   // last pair sits in the square stage
		logic out_free;      // output register can take a word
	} dp_sts_t;

	// 2^(-i/2^tbits) in Q.16, from a 20-term series in Q.30; elaboration only
	function automatic logic [16:0] pow2_entry(input int unsigned i,
			input int unsigned tbits);
		logic [63:0] u;
		logic [63:0] term;
		logic [63:0] pos;
		logic [63:0] neg;
		logic [63:0] t;
		u    = (64'(i) * LN2_Q30) >> tbits;
		term = 64'd1 << 30;
		pos  = term;
		neg  = '0;
		for (int n = 1; n <= 20; n++) begin
			t = (term * u) >> 30;
			case (n)
				1:  term = t;
				2:  term = t / 2;
				3:  term = t / 3;
				4:  term = t / 4;
				5:  term = t / 5;
				6:  term = t / 6;
				7:  term = t / 7;
				8:  term = t / 8;
				9:  term = t / 9;
				10: term = t / 10;
				11: term = t / 11;
				12: term = t / 12;
				13: term = t / 13;
				14: term = t / 14;
				15: term = t / 15;
				16: term = t / 16;
				17: term = t / 17;
				18: term = t / 18;
				19: term = t / 19;
				default: term = t / 20;
			endcase
			if ((n % 2) == 1) neg = neg + term;
			else pos = pos + term;
		end
		return 17'(((pos - neg) + 64'd8192) >> 14);
	endfunction

endpackage

`default_nettype wire

// File: rtl/rbfk_ctrl.sv
// Sequencer for the RBF kernel evaluator: accumulate, then the exp steps.
// Depends on rbfk_pkg; drives rbfk_dp through dp_cmd_t.
`default_nettype none

module rbfk_ctrl (
	input  wire               clk,
	input  wire               arst_n,
	input  rbfk_pkg::dp_sts_t sts,
	output rbfk_pkg::dp_cmd_t cmd
);
	import rbfk_pkg::*;

	typedef enum logic [2:0] {
		ST_ACCUM,
		ST_MUL_HI,
		ST_MUL_LO,
		ST_SCALE,
		ST_LOG,
		ST_INTERP,
		ST_ROUND
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACCUM;
		end else begin
			case (state_q)
				ST_ACCUM:  if (sts.fin_pending) state_q <= ST_MUL_HI;
				ST_MUL_HI: state_q <= ST_MUL_LO;
				ST_MUL_LO: state_q <= ST_SCALE;
				ST_SCALE:  state_q <= ST_LOG;
				ST_LOG:    state_q <= ST_INTERP;
				ST_INTERP: state_q <= ST_ROUND;
				ST_ROUND:  if (sts.out_free) state_q <= ST_ACCUM;
				default:   state_q <= ST_ACCUM;
			endcase
		end
	end

	always_comb begin
		cmd          = '0;
		cmd.in_ready = (state_q == ST_ACCUM) && !sts.fin_pending;
		cmd.mul_hi   = (state_q == ST_MUL_HI);
		cmd.mul_lo   = (state_q == ST_MUL_LO);
		cmd.scale    = (state_q == ST_SCALE);
		cmd.log2e    = (state_q == ST_LOG);
		cmd.interp   = (state_q == ST_INTERP);
		cmd.load_out = (state_q == ST_ROUND) && sts.out_free;
	end

endmodule

`default_nettype wire

// File: rtl/rbfk_dp.sv
// Datapath: square stage, saturating accumulator, scale multiply, exp table.
// Depends on rbfk_pkg; sequenced by rbfk_ctrl.
`default_nettype none

module rbfk_dp #(
	parameter int ELEM_FRAC_BITS = 8,
	parameter int EXP_TABLE_BITS = 8
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	input  wire  [15:0]       first_elem,
	input  wire  [15:0]       second_elem,
	input  wire               last_elem,
	input  wire  [31:0]       inv_gamma,
	input  rbfk_pkg::dp_cmd_t cmd,
	output rbfk_pkg::dp_sts_t sts,
	output logic              out_valid,
	input  wire               out_ready,
	output logic [15:0]       kernel_value,
	output logic              distance_saturated
);
	import rbfk_pkg::*;

	localparam int SHIFT       = 2 * ELEM_FRAC_BITS;
	localparam int INTERP_BITS = 16 - EXP_TABLE_BITS;
	localparam int TAB_LEN     = (1 << EXP_TABLE_BITS) + 1;
	localparam int DFR_W       = 17 + INTERP_BITS;
	localparam logic [55:0] PH_LIMIT = 56'd1 << 39;

	// square stage
	logic               valid_s1;
	logic               last_s1;
	logic [31:0]        sq_s1;
	logic signed [16:0] diff;
	logic signed [33:0] sq_full;

	// accumulator and captured total
	logic [47:0] acc_q;
	logic        sat_q;
	logic [48:0] acc_sum;
	logic [47:0] acc_clamp;
	logic        acc_ovf;
	logic [47:0] fin_acc_q;
	logic        fin_sat_q;

	// finishing steps
	logic [23:0]        mul_a;
	logic [55:0]        mul_p;
	logic [55:0]        ph_q;
	logic [55:0]        pl_q;
	logic [63:0]        p_sum;
	logic [63:0]        x_wide;
	logic [21:0]        x_q;
	logic [38:0]        y_mul;
	logic [22:0]        y_q;
	logic [16:0]        tab [TAB_LEN];
	logic [EXP_TABLE_BITS:0] idx0;
	logic [EXP_TABLE_BITS:0] idx1;
	logic [INTERP_BITS-1:0]  fr;
	logic [16:0]        tab_a;
	logic [16:0]        tab_d;
	logic [16:0]        a_q;
	logic [6:0]         k_q;
	logic [DFR_W-1:0]   dfr_q;
	logic [16:0]        v;
	logic [17:0]        rnd;
	logic [15:0]        kv_next;

	logic        out_valid_q;
	logic [15:0] kv_q;
	logic        sat_out_q;

	for (genvar g = 0; g < TAB_LEN; g++) begin : g_tab
		assign tab[g] = pow2_entry(g, EXP_TABLE_BITS);
	end

	assign diff    = $signed({first_elem[15], first_elem}) - $signed({second_elem[15], second_elem});
	assign sq_full = diff * diff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid && cmd.in_ready;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && cmd.in_ready) begin
			sq_s1   <= sq_full[31:0];
			last_s1 <= last_elem;
		end
	end

	assign acc_sum   = {1'b0, acc_q} + {17'd0, sq_s1};
	assign acc_ovf   = acc_sum[48];
	assign acc_clamp = acc_ovf ? ACC_MAX : acc_sum[47:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			sat_q <= 1'b0;
		end else if (valid_s1) begin
			if (last_s1) begin
				acc_q <= '0;
				sat_q <= 1'b0;
			end else begin
				acc_q <= acc_clamp;
				sat_q <= sat_q | acc_ovf;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && last_s1) begin
			fin_acc_q <= acc_clamp;
			fin_sat_q <= sat_q | acc_ovf;
		end
	end

	// one 24x32 multiplier, high half then low half
	assign mul_a = cmd.mul_lo ? fin_acc_q[23:0] : fin_acc_q[47:24];
	assign mul_p = 56'(mul_a) * 56'(inv_gamma);

	assign p_sum  = {ph_q[39:0], 24'd0} + {8'd0, pl_q};
	assign x_wide = p_sum >> SHIFT;
	assign y_mul  = 39'(x_q) * 39'(LOG2E_Q16);

	assign idx0  = {1'b0, y_q[15:INTERP_BITS]};
	assign idx1  = idx0 + 1'b1;
	assign fr    = y_q[INTERP_BITS-1:0];
	assign tab_a = tab[idx0];
	assign tab_d = tab_a - tab[idx1];

	assign v   = a_q - 17'(dfr_q >> INTERP_BITS);
	assign rnd = ({1'b0, v} + (18'd1 << k_q)) >> (k_q + 7'd1);
	always_comb begin
		if (k_q >= 7'd17) kv_next = '0;
		else if (rnd > 18'(KV_ONE)) kv_next = KV_ONE;
		else kv_next = rnd[15:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_hi) ph_q <= mul_p;
		if (cmd.mul_lo) pl_q <= mul_p;
		if (cmd.scale) begin
			x_q <= (ph_q >= PH_LIMIT || x_wide > 64'(X_MAX)) ? X_MAX : x_wide[21:0];
		end
		if (cmd.log2e) y_q <= y_mul[38:16];
		if (cmd.interp) begin
			a_q   <= tab_a;
			k_q   <= y_q[22:16];
			dfr_q <= DFR_W'(tab_d) * DFR_W'(fr);
		end
		if (cmd.load_out) begin
			kv_q      <= kv_next;
			sat_out_q <= fin_sat_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign sts.fin_pending = valid_s1 && last_s1;
	assign sts.out_free    = !out_valid_q || out_ready;

	assign out_valid          = out_valid_q;
	assign kernel_value       = kv_q;
	assign distance_saturated = sat_out_q;

endmodule

`default_nettype wire

// File: rtl/rbf_kernel_evaluate.sv
// Top level of the Gaussian RBF kernel evaluator.
// Depends on rbfk_pkg, rbfk_ctrl and rbfk_dp.
`default_nettype none

// Streams element pairs of two vectors (signed Q8.8, one pair per word) and
// returns exp(-|a-b|^2 * inv_gamma) as unsigned Q1.15 on the word marked
// tlast. Pairs are taken one per clock while the input is open; each
// difference is squared in a register stage and summed into a 48-bit
// accumulator that clamps at its maximum, the clamp showing up in
// m_axis_tuser of that vector's result. After the tlast word is taken,
// s_axis_tready stays low while the finishing sequence runs on one shared
// 24x32 multiplier (two halves of the distance times inv_gamma), the log2(e)
// multiply, the 2^-x table with linear interpolation, and rounding; the result
// lands in the output register and the input reopens in that same cycle. If
// the previous result has not been taken by then, the input stays closed
// until it is. inv_gamma (Q16.16, 1/gamma, reset 1.0) sits at address 0 of
// the APB port and should only be written while no vector is in flight.
module rbf_kernel_evaluate #(
	parameter int ELEM_FRAC_BITS = 8,
	parameter int EXP_TABLE_BITS = 8
) (
	input  wire         clk,
	input  wire         arst_n,
	// APB register port
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [2:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// input words
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [31:0] s_axis_tdata,    // [15:0] first_elem, [31:16] second_elem
	input  wire         s_axis_tlast,    // last_elem
	// result words
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [15:0] m_axis_tdata,    // [15:0] kernel_value
	output logic [0:0]  m_axis_tuser     // [0] distance_saturated
);
	import rbfk_pkg::*;

	logic [31:0] inv_gamma_q;
	dp_cmd_t     cmd;
	dp_sts_t     sts;
	logic        sat;

	// register write on the APB access cycle; low address bits ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_gamma_q <= INV_GAMMA_RST;
		end else if (psel && penable && pwrite && paddr[2:2] == REG_INV_GAMMA) begin
			inv_gamma_q <= pwdata;
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2:2] == REG_INV_GAMMA) ? inv_gamma_q : '0;

	rbfk_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	rbfk_dp #(
		.ELEM_FRAC_BITS (ELEM_FRAC_BITS),
		.EXP_TABLE_BITS (EXP_TABLE_BITS)
	) u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (s_axis_tvalid),
		.first_elem         (s_axis_tdata[15:0]),
		.second_elem        (s_axis_tdata[31:16]),
		.last_elem          (s_axis_tlast),
		.inv_gamma          (inv_gamma_q),
		.cmd                (cmd),
		.sts                (sts),
		.out_valid          (m_axis_tvalid),
		.out_ready          (m_axis_tready),
		.kernel_value       (m_axis_tdata),
		.distance_saturated (sat)
	);

	assign s_axis_tready = cmd.in_ready;
	assign m_axis_tuser  = sat;

endmodule

`default_nettype wire

// File: rtl/rbfk_checker.sv
// Port-level checks for the RBF kernel evaluator, bound to the top level.
// Depends on rbfk_pkg and rbf_kernel_evaluate.
`default_nettype none

module rbfk_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        psel,
	input wire        penable,
	input wire        pwrite,
	input wire [2:0]  paddr,
	input wire [31:0] pwdata,
	input wire [31:0] prdata,
	input wire        pready,
	input wire        s_axis_tvalid,
	input wire        s_axis_tready,
	input wire        s_axis_tlast,
	input wire        m_axis_tvalid,
	input wire        m_axis_tready,
	input wire [15:0] m_axis_tdata,
	input wire [0:0]  m_axis_tuser
);
	import rbfk_pkg::*;

	// result never exceeds 1.0
	a_kv_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata <= KV_ONE)
		else $error("kernel value above 1.0");

	// stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result word changed while stalled");

	// input closes while the finishing sequence runs
	a_last_closes: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tlast |=> ##1 !s_axis_tready)
		else $error("input reopened during finishing");

	// a written inv_gamma reads back
	a_cfg_readback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && pready && paddr[2:2] == REG_INV_GAMMA |=>
			paddr[2:2] != REG_INV_GAMMA || prdata == $past(pwdata))
		else $error("inv_gamma read-back mismatch");

endmodule

bind rbf_kernel_evaluate rbfk_checker u_rbfk_checker (.*);

`default_nettype wire

// File: tb/sv/tb_rbf_kernel_evaluate.sv
// Self-checking testbench for rbf_kernel_evaluate: streams element pairs, predicts each
// kernel word from its own fixed-point exp model and compares the result stream field by field.
// Depends on rbfk_pkg and the rbf_kernel_evaluate RTL only.
`default_nettype none

module tb_rbf_kernel_evaluate;
	timeunit 1ns;
	timeprecision 1ps;

	import rbfk_pkg::*;

	localparam int FRAC_BITS   = 8;
	localparam int TAB_BITS    = 8;
	localparam int TAB_LEN     = (1 << TAB_BITS) + 1;
	localparam int INTERP_BITS = 16 - TAB_BITS;
	localparam logic [2:0] INV_GAMMA_ADDR = {REG_INV_GAMMA, 2'b00};
	localparam int PLAN_ROWS   = 18;
	localparam int RAND_PHASES = 8;
	localparam int PHASE_PAIRS = 45;

	// one result word: kernel value and the saturation flag carried in tuser
	typedef struct packed {
		logic [15:0] value;
		logic        sat;
	} kernel_word_t;

	// directed row: the pair is sent reps times; typed rows carry the known answer
	typedef struct packed {
		logic [15:0] first;
		logic [15:0] second;
		logic        last;
		logic [16:0] reps;
		logic        typed;
		logic [15:0] kv;
		logic        sat;
	} pair_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;    // [15:0] first_elem, [31:16] second_elem
	logic        s_axis_tlast = 1'b0;  // last_elem
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;         // [15:0] kernel_value
	logic [0:0]  m_axis_tuser;         // [0] distance_saturated

	// predictor state, mirrors the block's accumulator and register
	int unsigned       pow2_q16 [TAB_LEN];
	longint unsigned   dist_sum = 0;
	logic              sat_seen = 1'b0;
	logic [31:0]       inv_gamma_model = INV_GAMMA_RST;
	kernel_word_t      kernel_expected [$];

	int  errors = 0;
	int  results_seen = 0;
	int  burst_left = 0;
	bit  squeeze_req = 1'b0;
	bit  squeeze_done = 1'b0;

	// Directed pairs, all at inv_gamma = 1.0. Known answers are typed in where obvious:
	// zero distance gives 1.0, any full-scale difference drives x past the clamp and gives 0.
	pair_row_t plan [PLAN_ROWS] = '{
		'{16'h0000, 16'h0000, 1'b1, 17'd1,     1'b1, KV_ONE, 1'b0},  // zero distance
		'{16'h7FFF, 16'h8000, 1'b1, 17'd1,     1'b1, 16'd0,  1'b0},  // largest difference
		'{16'h8000, 16'h7FFF, 1'b1, 17'd1,     1'b1, 16'd0,  1'b0},  // largest, negative
		'{16'h8000, 16'h8000, 1'b1, 17'd1,     1'b1, KV_ONE, 1'b0},  // both most negative
		'{16'h7FFF, 16'h7FFF, 1'b1, 17'd1,     1'b1, KV_ONE, 1'b0},  // both most positive
		'{16'h0100, 16'h0000, 1'b1, 17'd1,     1'b0, 16'd0,  1'b0},  // distance 1.0: exp(-1)
		'{16'h0000, 16'h0080, 1'b1, 17'd1,     1'b0, 16'd0,  1'b0},  // half step, negative
		'{16'h0001, 16'h0000, 1'b0, 17'd1,     1'b0, 16'd0,  1'b0},  // three-pair vector
		'{16'hFFFF, 16'h0001, 1'b0, 17'd1,     1'b0, 16'd0,  1'b0},
		'{16'h0040, 16'hFFC0, 1'b1, 17'd1,     1'b0, 16'd0,  1'b0},
		'{16'hAAAA, 16'h5555, 1'b1, 17'd1,     1'b1, 16'd0,  1'b0},  // alternating bits
		'{16'h5555, 16'hAAAA, 1'b1, 17'd1,     1'b1, 16'd0,  1'b0},
		'{16'h0010, 16'h0000, 1'b0, 17'd3,     1'b0, 16'd0,  1'b0},  // small repeated pairs
		'{16'h0000, 16'h0010, 1'b1, 17'd1,     1'b0, 16'd0,  1'b0},
		'{16'h7FFF, 16'h8000, 1'b0, 17'd4,     1'b0, 16'd0,  1'b0},  // four full-scale pairs
		'{16'h0000, 16'h0000, 1'b1, 17'd1,     1'b1, 16'd0,  1'b0},  // x clamped: zero
		'{16'h0000, 16'h0000, 1'b1, 17'd1,     1'b1, KV_ONE, 1'b0},  // sum cleared again
		'{16'h00FF, 16'hFF01, 1'b1, 17'd1,     1'b0, 16'd0,  1'b0}
	};

	rbf_kernel_evaluate #(
		.ELEM_FRAC_BITS(FRAC_BITS),
		.EXP_TABLE_BITS(TAB_BITS)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	always #6 clk = ~clk;

	function automatic void flag_error(input string msg);
		errors++;
		if (errors <= 10) $display("mismatch: %s", msg);
	endfunction

	// 2^(-i/2^TAB_BITS) in Q.16: alternating Taylor series of exp(-i*ln2/2^TAB_BITS) in Q.30
	function automatic void build_pow2_table();
		longint unsigned u;
		longint unsigned term;
		longint unsigned plus;
		longint unsigned minus;
		for (int i = 0; i < TAB_LEN; i++) begin
			u     = (longint'(i) * LN2_Q30) >> TAB_BITS;
			term  = 64'd1 << 30;
			plus  = term;
			minus = 0;
			for (int n = 1; n <= 20; n++) begin
				term = ((term * u) >> 30) / n;
				if (n % 2) minus += term;
				else plus += term;
			end
			pow2_q16[i] = int'(((plus - minus) + 64'd8192) >> 14);
		end
	endfunction

	// distance * inv_gamma, back to Q.16, clamped at 32.0; split so the product never wraps
	function automatic longint unsigned scale_by_gamma(input longint unsigned acc,
			input logic [31:0] g);
		longint unsigned hi;
		longint unsigned lo;
		longint unsigned x;
		hi = (acc >> 24) * g;
		lo = (acc & 64'hFF_FFFF) * g;
		if (hi >= (64'd1 << 39)) return X_MAX;
		x = ((hi << 24) + lo) >> (2 * FRAC_BITS);
		return (x > X_MAX) ? X_MAX : x;
	endfunction

	// exp(-x) = 2^-(x*log2 e): table plus linear interpolation, then shift and round to Q1.15
	function automatic logic [15:0] exp_neg_q15(input longint unsigned x);
		longint unsigned y;
		longint unsigned k;
		int unsigned r;
		int unsigned idx;
		int unsigned fr;
		int unsigned a;
		int unsigned d;
		int unsigned v;
		int unsigned q;
		y   = (x * LOG2E_Q16) >> 16;
		k   = y >> 16;
		r   = int'(y & 64'hFFFF);
		idx = r >> INTERP_BITS;
		fr  = r & ((1 << INTERP_BITS) - 1);
		a   = pow2_q16[idx];
		d   = a - pow2_q16[idx + 1];
		v   = a - ((d * fr) >> INTERP_BITS);
		if (k >= 17) return 16'd0;
		q = (v + (32'd1 << k)) >> (k + 1);
		return (q > KV_ONE) ? KV_ONE : q[15:0];
	endfunction

	// adds one pair to the running distance; on the last pair returns the kernel word
	function automatic bit fold_pair(input logic [15:0] a, input logic [15:0] b,
			input logic last, output kernel_word_t w);
		int diff;
		longint unsigned mag;
		longint unsigned sum;
		diff = int'($signed(a)) - int'($signed(b));
		mag  = (diff < 0) ? -diff : diff;
		sum  = dist_sum + mag * mag;
		if (sum > ACC_MAX) begin
			sum      = ACC_MAX;
			sat_seen = 1'b1;
		end
		dist_sum = sum;
		w = '0;
		if (!last) return 1'b0;
		w.value  = exp_neg_q15(scale_by_gamma(dist_sum, inv_gamma_model));
		w.sat    = sat_seen;
		dist_sum = 0;
		sat_seen = 1'b0;
		return 1'b1;
	endfunction

	// Sender: bursts of random length with random gaps. Word changes at the falling edge,
	// acceptance is seen at the rising edge. A typed row overrides the predicted word.
	task automatic drive_pair(input logic [15:0] a, input logic [15:0] b, input logic last,
			input bit typed, input kernel_word_t typed_word);
		int gap;
		kernel_word_t w;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				@(negedge clk) s_axis_tvalid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {b, a};
		s_axis_tlast  <= last;
		do @(posedge clk); while (!s_axis_tready);
		if (fold_pair(a, b, last, w)) kernel_expected.push_back(typed ? typed_word : w);
	endtask

	// quiet the input, let outstanding words come back, then allow for the finishing pass
	task automatic settle_block();
		@(negedge clk) s_axis_tvalid <= 1'b0;
		burst_left = 0;
		for (int n = 0; n < 20000 && kernel_expected.size() != 0; n++) @(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	// one APB transfer on the inv_gamma register: setup then access cycle
	task automatic apb_access(input logic wr, input logic [31:0] wdata,
			output logic [31:0] rdata);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= INV_GAMMA_ADDR;
		pwdata  <= wdata;
		@(negedge clk) penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic load_inv_gamma(input logic [31:0] g);
		logic [31:0] back;
		apb_access(1'b1, g, back);
		apb_access(1'b0, '0, back);
		if (back !== g) flag_error($sformatf("inv_gamma read back %h, want %h", back, g));
		inv_gamma_model = g;
	endtask

	// element classes: full range, within +-8.0, within +-0.25
	function automatic logic [15:0] pick_elem(input int cls);
		case (cls)
			0:       return 16'($urandom);
			1:       return 16'(int'($urandom_range(0, 4096)) - 2048);
			default: return 16'(int'($urandom_range(0, 128)) - 64);
		endcase
	endfunction

	// Result side: every accepted word is checked against the oldest expectation.
	always @(posedge clk) begin : check_result
		kernel_word_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			results_seen++;
			if (kernel_expected.size() == 0) begin
				flag_error($sformatf("unexpected word kv=%0d sat=%0b", m_axis_tdata,
					m_axis_tuser[0]));
			end else begin
				want = kernel_expected.pop_front();
				if (m_axis_tdata !== want.value || m_axis_tuser[0] !== want.sat)
					flag_error($sformatf("word %0d: want kv=%0d sat=%0b, got kv=%0d sat=%0b",
						results_seen, want.value, want.sat, m_axis_tdata, m_axis_tuser[0]));
			end
		end
	end

	// Receiver: ready runs, mostly short with the odd long one, broken by short stalls.
	// Once asked, it holds ready low so the block fills and closes its input.
	initial begin : rx_pattern
		int run_len;
		forever begin
			if (squeeze_req && !squeeze_done) begin
				@(negedge clk) m_axis_tready <= 1'b0;
				repeat (299) @(negedge clk);
				squeeze_done = 1'b1;
			end else begin
				run_len = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 160)
					: $urandom_range(1, 10);
				@(negedge clk) m_axis_tready <= 1'b1;
				repeat (run_len - 1) @(negedge clk);
				if ($urandom_range(0, 2) != 0) begin
					run_len = $urandom_range(1, 5);
					@(negedge clk) m_axis_tready <= 1'b0;
					repeat (run_len - 1) @(negedge clk);
				end
			end
		end
	end

	// Watchdog. An honest run is some 420 words; even with every word a last word,
	// the longest gaps and stalls and the hold-off it ends well inside 3 ms.
	initial begin
		#3_000_000;
		$display("status: fail");
		$finish;
	end

	initial begin : stimulus
		logic [31:0] back;
		logic [31:0] g;
		logic [15:0] ea;
		logic [15:0] eb;
		int vec_len;
		int cls;
		int sent;
		build_pow2_table();
		repeat (11) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset value first, then an explicit write of 1.0
		apb_access(1'b0, '0, back);
		if (back !== INV_GAMMA_RST)
			flag_error($sformatf("inv_gamma after reset %h, want %h", back, INV_GAMMA_RST));
		load_inv_gamma(INV_GAMMA_RST);

		for (int r = 0; r < PLAN_ROWS; r++)
			for (int n = 0; n < plan[r].reps; n++)
				drive_pair(plan[r].first, plan[r].second, plan[r].last, plan[r].typed,
					{plan[r].kv, plan[r].sat});

		// random vectors under a spread of inv_gamma settings; each phase ends on a
		// last word, so the register is only touched between vectors
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			settle_block();
			case (ph)
				0:       g = 32'h0000_0000;        // gamma infinite: always 1.0
				1:       g = 32'hFFFF_FFFF;
				2:       g = 32'h0000_0001;
				3:       g = INV_GAMMA_RST;
				4:       g = 32'h0000_2000;
				5:       g = $urandom_range(0, 32'h0010_0000);
				6:       g = $urandom;
				default: g = 32'h0000_0100;
			endcase
			load_inv_gamma(g);
			if (ph == 3) squeeze_req = 1'b1;
			sent = 0;
			while (sent < PHASE_PAIRS) begin
				vec_len = $urandom_range(1, 8);
				cls     = $urandom_range(0, 3);
				for (int j = 0; j < vec_len; j++) begin
					ea = pick_elem(cls == 3 ? 0 : cls);
					eb = (cls == 3) ? ea : pick_elem(cls);
					drive_pair(ea, eb, j == vec_len - 1, 1'b0, '0);
					sent++;
				end
			end
		end

		settle_block();
		if (kernel_expected.size() != 0)
			flag_error($sformatf("%0d words never arrived", kernel_expected.size()));
		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

`default_nettype wire

// File: rbf_kernel_evaluate.f
rtl/rbfk_pkg.sv
rtl/rbfk_ctrl.sv
rtl/rbfk_dp.sv
rtl/rbf_kernel_evaluate.sv
rtl/rbfk_checker.sv
tb/sv/tb_rbf_kernel_evaluate.sv
